// File: src/lgi_pkg.sv
// ----------------------------------------------------------------------------
// lgi_pkg
// Shared types and constants for the linear gap interpolator.
// ----------------------------------------------------------------------------
package lgi_pkg;

  // Width of the pending gap counter and of the divisor (gap + 1).
  localparam int unsigned GapW = 6;
  localparam int unsigned DivW = GapW + 1;

  // Input item kinds carried on tuser.
  typedef enum logic [1:0] {
    OP_SAMPLE  = 2'd0,
    OP_MISSING = 2'd1,
    OP_END     = 2'd2,
    OP_UNUSED  = 2'd3
  } op_e;

  // Sequencer states, one-hot.
  typedef enum logic [7:0] {
    ST_IDLE  = 8'b0000_0001,
    ST_DIFF  = 8'b0000_0010,
    ST_ABS   = 8'b0000_0100,
    ST_DIV   = 8'b0000_1000,
    ST_PREP  = 8'b0001_0000,
    ST_FILL  = 8'b0010_0000,
    ST_PASS  = 8'b0100_0000,
    ST_FLUSH = 8'b1000_0000
  } state_e;

endpackage

// File: src/lgi_div.sv
// ----------------------------------------------------------------------------
// lgi_div
// Restoring divider: unsigned dividend by a narrow divisor, one quotient bit
// per cycle. Quotient and remainder hold until the next start.
// ----------------------------------------------------------------------------
module lgi_div
  import lgi_pkg::*;
#(
  parameter int unsigned SAMPLE_WIDTH = 32
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic [SAMPLE_WIDTH-1:0] dividend_i,
  input  logic [DivW-1:0]         divisor_i,
  output logic                    done_o,
  output logic [SAMPLE_WIDTH-1:0] quotient_o,
  output logic [DivW-1:0]         remainder_o
);

  localparam int unsigned CntW = $clog2(SAMPLE_WIDTH + 1);

  logic [SAMPLE_WIDTH-1:0] quo_q, quo_d;
  logic [DivW-1:0]         rem_q, rem_d;
  logic [CntW-1:0]         cnt_q, cnt_d;
  logic                    busy_q, busy_d;
  logic                    done_q, done_d;
  logic [DivW-1:0]         shifted;
  logic [DivW:0]           trial;

  // Remainder stays below the divisor (at most 64), so its top bit is clear.
  assign shifted = {rem_q[DivW-2:0], quo_q[SAMPLE_WIDTH-1]};
  assign trial   = {1'b0, shifted} - {1'b0, divisor_i};

  always_comb begin
    quo_d  = quo_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      quo_d  = dividend_i;
      rem_d  = '0;
      cnt_d  = CntW'(SAMPLE_WIDTH);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (!trial[DivW]) begin
        rem_d = trial[DivW-1:0];
        quo_d = {quo_q[SAMPLE_WIDTH-2:0], 1'b1};
      end else begin
        rem_d = shifted;
        quo_d = {quo_q[SAMPLE_WIDTH-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
  end

  assign done_o      = done_q;
  assign quotient_o  = quo_q;
  assign remainder_o = rem_q;

endmodule

// File: src/linear_gap_interpolator_top.sv
// ----------------------------------------------------------------------------
// linear_gap_interpolator_top
// Fills runs of missing samples by exact linear interpolation between the
// surrounding valid samples, truncated toward zero.
//
// Channel  Dir  tdata           tuser     tlast
// s_axis   in   sample          op        -
// m_axis   out  value           -         last
//
// A missing marker is only counted into the gap, saturating at MAX_GAP. A valid
// sample with no pending gap is passed straight to the output. A valid sample
// after missing ones steps through difference, absolute value, the bit-serial
// divider and increment setup, then outputs the filled values and the sample.
// End of column outputs one value per pending gap.
// Reset clears the column state; output stalls hold fill, pass and flush in place.
// ----------------------------------------------------------------------------
module linear_gap_interpolator_top
  import lgi_pkg::*;
#(
  parameter int unsigned SAMPLE_WIDTH = 32,
  parameter int unsigned MAX_GAP      = 63
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid_i,
  output logic                                s_axis_tready_o,
  // tdata: sample
  input  logic [((SAMPLE_WIDTH+7)/8)*8-1:0]   s_axis_tdata_i,
  // tuser: op
  input  logic [1:0]                          s_axis_tuser_i,
  output logic                                m_axis_tvalid_o,
  input  logic                                m_axis_tready_i,
  // tdata: value
  output logic [((SAMPLE_WIDTH+7)/8)*8-1:0]   m_axis_tdata_o,
  output logic                                m_axis_tlast_o
);

  localparam int unsigned TdW = ((SAMPLE_WIDTH + 7) / 8) * 8;
  localparam int unsigned SW  = SAMPLE_WIDTH;

  state_e          state_q, state_d;
  logic            have_good_q, have_good_d;
  logic [SW-1:0]   last_good_q, last_good_d;
  logic [GapW-1:0] gap_q, gap_d;
  logic [GapW-1:0] idx_q, idx_d;
  logic [SW-1:0]   b_q, b_d;
  logic [SW-1:0]   val_q, val_d;
  logic [SW:0]     diff_q, diff_d;
  logic            dir_q, dir_d;
  logic [SW-1:0]   inc0_q, inc0_d;
  logic [SW-1:0]   inc1_q, inc1_d;
  logic [DivW-1:0] acc_r_q, acc_r_d;

  logic            out_valid_q, out_valid_d;
  logic [SW-1:0]   out_data_q, out_data_d;
  logic            out_last_q, out_last_d;
  logic            out_free;

  logic            in_acc;
  op_e             op;
  logic [SW-1:0]   sample;
  logic [SW-1:0]   a_sel;
  logic [DivW-1:0] n_div;

  logic            div_start;
  logic [SW-1:0]   div_dividend;
  logic            div_done;
  logic [SW-1:0]   div_quo;
  logic [DivW-1:0] div_rem;

  logic [DivW:0]   r_sum;
  logic            carry;
  logic [SW-1:0]   val_next;

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;
  assign op              = op_e'(s_axis_tuser_i);
  assign sample          = s_axis_tdata_i[SW-1:0];
  assign a_sel           = have_good_q ? last_good_q : sample;
  assign n_div           = {1'b0, gap_q} + DivW'(1);
  assign out_free        = !out_valid_q || m_axis_tready_i;

  // Absolute difference feeds the divider.
  assign div_dividend = diff_q[SW] ? (~diff_q[SW-1:0] + SW'(1)) : diff_q[SW-1:0];

  // Step the running fraction r0*i mod n; a wrap adds one more unit.
  assign r_sum    = {1'b0, acc_r_q} + {1'b0, div_rem};
  assign carry    = (r_sum >= {1'b0, n_div});
  assign val_next = val_q + (carry ? inc1_q : inc0_q);

  lgi_div #(
    .SAMPLE_WIDTH(SW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (n_div),
    .done_o     (div_done),
    .quotient_o (div_quo),
    .remainder_o(div_rem)
  );

  always_comb begin
    state_d     = state_q;
    have_good_d = have_good_q;
    last_good_d = last_good_q;
    gap_d       = gap_q;
    idx_d       = idx_q;
    b_d         = b_q;
    val_d       = val_q;
    diff_d      = diff_q;
    dir_d       = dir_q;
    inc0_d      = inc0_q;
    inc1_d      = inc1_q;
    acc_r_d     = acc_r_q;
    out_valid_d = m_axis_tready_i ? 1'b0 : out_valid_q;
    out_data_d  = out_data_q;
    out_last_d  = out_last_q;
    div_start   = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          unique case (op)
            OP_SAMPLE: begin
              b_d   = sample;
              val_d = a_sel;
              state_d = (gap_q == '0) ? ST_PASS : ST_DIFF;
            end
            OP_MISSING: begin
              if (gap_q < GapW'(MAX_GAP)) begin
                gap_d = gap_q + 1'b1;
              end
            end
            OP_END: begin
              if (gap_q == '0) begin
                have_good_d = 1'b0;
                last_good_d = '0;
              end else begin
                val_d   = have_good_q ? last_good_q : '0;
                idx_d   = GapW'(1);
                state_d = ST_FLUSH;
              end
            end
            default: ;
          endcase
        end
      end
      ST_DIFF: begin
        diff_d  = {b_q[SW-1], b_q} - {val_q[SW-1], val_q};
        state_d = ST_ABS;
      end
      ST_ABS: begin
        dir_d     = !diff_q[SW];
        div_start = 1'b1;
        state_d   = ST_DIV;
      end
      ST_DIV: begin
        if (div_done) begin
          state_d = ST_PREP;
        end
      end
      ST_PREP: begin
        // Per-step increments: +/- q0, and +/- (q0 + 1) on a fraction wrap.
        inc0_d  = dir_q ? div_quo : (~div_quo + SW'(1));
        inc1_d  = dir_q ? (div_quo + SW'(1)) : ~div_quo;
        acc_r_d = '0;
        idx_d   = GapW'(1);
        state_d = ST_FILL;
      end
      ST_FILL: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_data_d  = val_next;
          out_last_d  = 1'b0;
          val_d       = val_next;
          acc_r_d     = carry ? (r_sum[DivW-1:0] - n_div) : r_sum[DivW-1:0];
          idx_d       = idx_q + 1'b1;
          if (idx_q == gap_q) begin
            state_d = ST_PASS;
          end
        end
      end
      ST_PASS: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_data_d  = b_q;
          out_last_d  = 1'b1;
          last_good_d = b_q;
          have_good_d = 1'b1;
          gap_d       = '0;
          state_d     = ST_IDLE;
        end
      end
      ST_FLUSH: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_data_d  = val_q;
          out_last_d  = (idx_q == gap_q);
          idx_d       = idx_q + 1'b1;
          if (idx_q == gap_q) begin
            // Start the next column from reset values.
            have_good_d = 1'b0;
            last_good_d = '0;
            gap_d       = '0;
            state_d     = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      have_good_q <= 1'b0;
      last_good_q <= '0;
      gap_q       <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      have_good_q <= have_good_d;
      last_good_q <= last_good_d;
      gap_q       <= gap_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    b_q        <= b_d;
    val_q      <= val_d;
    diff_q     <= diff_d;
    dir_q      <= dir_d;
    inc0_q     <= inc0_d;
    inc1_q     <= inc1_d;
    acc_r_q    <= acc_r_d;
    out_data_q <= out_data_d;
    out_last_q <= out_last_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = TdW'(out_data_q);
  assign m_axis_tlast_o  = out_last_q;

endmodule

// File: bench/linear_gap_interpolator_top_test.sv
// ----------------------------------------------------------------------------
// linear_gap_interpolator_top_test
// Self-checking bench for the gap interpolator. A scoreboard predicts the
// filled and passed-through values for every accepted request and compares
// them in order with the output stream. Directed columns cover the edge
// cases, then random columns run with idle cycles and output back-pressure.
// ----------------------------------------------------------------------------
module linear_gap_interpolator_top_test
  import lgi_pkg::*;
;

  localparam int unsigned SampleW = 32;
  localparam int unsigned MaxGap  = 63;
  localparam int unsigned HoldOff = 300;

  typedef struct packed {
    logic [SampleW-1:0] value;
    logic               last;
  } fill_t;

  class gap_fill_scoreboard;
    logic                      seen_sample;
    logic signed [SampleW-1:0] prev_sample;
    logic [GapW-1:0]           pending_gaps;
    fill_t                     expected_q[$];
    int                        mismatches;
    int                        requests;
    int                        results_checked;
    int                        fills;
    int                        column_ends;
    int                        saturations;

    function new();
      seen_sample     = 1'b0;
      prev_sample     = '0;
      pending_gaps    = '0;
      mismatches      = 0;
      requests        = 0;
      results_checked = 0;
      fills           = 0;
      column_ends     = 0;
      saturations     = 0;
    endfunction

    // a + trunc((b - a) * i / n), exact in 64 bits
    function logic [SampleW-1:0] lerp(logic signed [SampleW-1:0] a,
                                      logic signed [SampleW-1:0] b, int i, int n);
      longint span;
      longint step;
      span = longint'(b) - longint'(a);
      step = (span * longint'(i)) / longint'(n);
      return SampleW'(longint'(a) + step);
    endfunction

    function void push(logic [SampleW-1:0] value, logic last);
      fill_t f;
      f.value = value;
      f.last  = last;
      expected_q.insert(expected_q.size(), f);
    endfunction

    function void note_request(op_e op, logic [SampleW-1:0] sample);
      logic signed [SampleW-1:0] start;
      int                        gaps;
      gaps = int'(pending_gaps);
      if (op != OP_UNUSED) requests++;
      case (op)
        OP_SAMPLE: begin
          // a gap at column start takes the new sample on both ends
          start = seen_sample ? prev_sample : sample;
          for (int i = 1; i <= gaps; i++) begin
            push(lerp(start, sample, i, gaps + 1), 1'b0);
            fills++;
          end
          push(sample, 1'b1);
          pending_gaps = '0;
          prev_sample  = sample;
          seen_sample  = 1'b1;
        end
        OP_MISSING: begin
          if (gaps < MaxGap) pending_gaps = pending_gaps + 1'b1;
          else saturations++;
        end
        OP_END: begin
          for (int i = 0; i < gaps; i++)
            push(seen_sample ? prev_sample : '0, i + 1 == gaps);
          seen_sample  = 1'b0;
          prev_sample  = '0;
          pending_gaps = '0;
          column_ends++;
        end
        default: ;
      endcase
    endfunction

    function void check_result(logic [SampleW-1:0] value, logic last);
      fill_t want;
      results_checked++;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: unexpected result value=%0d last=%0b", $signed(value), last);
        return;
      end
      want = expected_q.pop_front();
      if (want.value !== value || want.last !== last) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: expected value=%0d last=%0b, got value=%0d last=%0b",
                   $signed(want.value), want.last, $signed(value), last);
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic               clk_i    = 1'b0;
  logic               rst_ni   = 1'b0;
  logic               s_tvalid = 1'b0;
  logic [SampleW-1:0] s_tdata  = '0;
  logic [1:0]         s_tuser  = OP_SAMPLE;
  logic               m_tready = 1'b0;
  logic               s_axis_tready_o;
  logic               m_axis_tvalid_o;
  logic [SampleW-1:0] m_axis_tdata_o;
  logic               m_axis_tlast_o;

  gap_fill_scoreboard sb;
  bit                 idle_on = 1'b0;
  bit                 hold_off_req = 1'b0;
  int                 items_sent = 0;

  linear_gap_interpolator_top #(
    .SAMPLE_WIDTH(SampleW),
    .MAX_GAP     (MaxGap)
  ) u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_tvalid),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_tdata),
    .s_axis_tuser_i (s_tuser),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_tready),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tlast_o (m_axis_tlast_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  initial begin
    #20_000_000;
    $display("== FAIL ==");
    $finish;
  end

  // Output side: random stalls, or one long hold-off on request.
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        m_tready <= 1'b0;
        repeat (HoldOff - 1) @(posedge clk_i);
      end else begin
        m_tready <= idle_on ? ($urandom_range(99) >= 16) : 1'b1;
      end
    end
  end

  // Note requests before checking results so a same-edge result still finds it.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_tvalid && s_axis_tready_o) sb.note_request(op_e'(s_tuser), s_tdata);
      if (m_axis_tvalid_o && m_tready) sb.check_result(m_axis_tdata_o, m_axis_tlast_o);
    end
  end

  task automatic send(op_e op, logic [SampleW-1:0] sample);
    while (idle_on && $urandom_range(99) < 16) begin
      s_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= sample;
    s_tuser  <= op;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    if (op != OP_UNUSED) items_sent++;
  endtask

  task automatic send_gap(int k);
    repeat (k) send(OP_MISSING, $urandom);
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  function automatic logic [SampleW-1:0] pick_sample();
    case ($urandom_range(3))
      0: return $urandom;
      1: return SampleW'($urandom_range(200) - 100);
      2: case ($urandom_range(3))
           0: return 32'h7FFF_FFFF;
           1: return 32'h8000_0000;
           2: return '0;
           default: return '1;
         endcase
      default: return SampleW'($urandom_range(1_000_000));
    endcase
  endfunction

  function automatic int pick_gap();
    case ($urandom_range(19))
      0, 1, 2, 3, 4, 5, 6, 7: return 0;
      8, 9, 10, 11, 12, 13, 14, 15: return $urandom_range(1, 5);
      16, 17, 18: return $urandom_range(6, 20);
      default: return $urandom_range(55, 70);
    endcase
  endfunction

  initial begin
    int pick;
    sb = new();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed columns
    send_gap(3);
    send(OP_SAMPLE, 32'd5);                // leading gap copies the sample
    send_gap(2);
    send(OP_SAMPLE, -32'sd7);              // falling span, truncation toward zero
    send_gap(1);
    send(OP_SAMPLE, 32'h7FFF_FFFF);
    send_gap(2);
    send(OP_SAMPLE, 32'h8000_0000);        // widest negative span
    send(OP_UNUSED, 32'hFFFF_FFFF);
    send(OP_SAMPLE, 32'd0);
    send_gap(1);
    send(OP_END, 32'h1234_5678);           // trailing gap repeats last sample
    send(OP_END, 32'hFFFF_FFFF);           // nothing pending
    send_gap(2);
    send(OP_END, 32'd0);                   // no sample in column: zeros
    wait_drained();

    // Longest fill, then a saturated gap in a sample and in an end of column
    send(OP_SAMPLE, 32'h8000_0000);
    send_gap(MaxGap);
    send(OP_SAMPLE, 32'h7FFF_FFFF);
    send_gap(MaxGap + 4);
    send(OP_SAMPLE, -32'sd1000);
    send_gap(MaxGap + 2);
    send(OP_END, 32'd0);

    // Receiver holds off while requests keep coming
    hold_off_req = 1'b1;
    idle_on = 1'b0;
    repeat (4) begin
      send_gap($urandom_range(2, 12));
      send(OP_SAMPLE, pick_sample());
      send(OP_SAMPLE, pick_sample());
    end
    wait_drained();

    // Random columns; a stretch in the middle runs with no idling
    idle_on = 1'b1;
    while (items_sent < 360) begin
      idle_on = !(items_sent >= 230 && items_sent < 300);
      pick = $urandom_range(99);
      if (pick < 70) begin
        send_gap(pick_gap());
        send(OP_SAMPLE, pick_sample());
      end else if (pick < 82) begin
        send_gap(pick_gap());
        send(OP_END, $urandom);
      end else if (pick < 92) begin
        send(op_e'($urandom_range(3)), $urandom);
      end else begin
        // broken column: unused code inside a gap
        send_gap($urandom_range(1, 4));
        send(OP_UNUSED, $urandom);
        send_gap($urandom_range(0, 3));
        send(op_e'($urandom_range(0, 2)), pick_sample());
      end
    end
    wait_drained();
    repeat (100) @(posedge clk_i);

    $display("run: %0d requests, %0d results checked, %0d interpolated values",
             sb.requests, sb.results_checked, sb.fills);
    $display("run: %0d column ends, %0d missing samples past saturation, %0d mismatches",
             sb.column_ends, sb.saturations, sb.mismatches);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
